FILE: rtl/svge_pkg.sv
// Shared types, codes and coefficient helpers of the state-vector gate engine.
package svge_pkg;

  localparam int CoefW = 19;
  localparam int CoefShift = 16;

  typedef logic signed [CoefW-1:0] coef_t;

  localparam coef_t COEF_ONE = 19'sd65536;
  localparam coef_t COEF_MONE = -19'sd65536;
  // 1/sqrt(2) in Q2.16, rounded to nearest.
  localparam coef_t COEF_K = 19'sd46341;
  localparam coef_t COEF_MK = -19'sd46341;
  localparam coef_t COEF_ZERO = 19'sd0;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_GATE = 2'd2;

  localparam logic [3:0] GK_X = 4'd0;
  localparam logic [3:0] GK_Y = 4'd1;
  localparam logic [3:0] GK_Z = 4'd2;
  localparam logic [3:0] GK_H = 4'd3;
  localparam logic [3:0] GK_S = 4'd4;
  localparam logic [3:0] GK_SDG = 4'd5;
  localparam logic [3:0] GK_T = 4'd6;
  localparam logic [3:0] GK_TDG = 4'd7;
  localparam logic [3:0] GK_CNOT = 4'd8;
  localparam logic [3:0] GK_RX = 4'd9;
  localparam logic [3:0] GK_RY = 4'd10;
  localparam logic [3:0] GK_RZ = 4'd11;

  // Operand selectors of the pair (a, b).
  localparam logic [1:0] SEL_AR = 2'd0;
  localparam logic [1:0] SEL_AI = 2'd1;
  localparam logic [1:0] SEL_BR = 2'd2;
  localparam logic [1:0] SEL_BI = 2'd3;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_GATE,
    CMD_NONE,
    CMD_FAIL
  } cmd_t;

  // One result part is coef1*operand1 + coef2*operand2, rounded and saturated.
  typedef struct packed {
    logic [1:0] sel1;
    coef_t      coef1;
    logic [1:0] sel2;
    coef_t      coef2;
  } term_t;

  // Index 0 a.re, 1 a.im, 2 b.re, 3 b.im.
  typedef term_t [3:0] terms_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] tgt;
    logic [3:0] ctl;
    logic       cnot;
    logic [4:0] nq;
  } ctrl_t;

  function automatic term_t mk_term(logic [1:0] s1, coef_t c1, logic [1:0] s2, coef_t c2);
    term_t t;
    t.sel1 = s1;
    t.coef1 = c1;
    t.sel2 = s2;
    t.coef2 = c2;
    return t;
  endfunction

  function automatic terms_t ident_terms();
    terms_t t;
    t[0] = mk_term(SEL_AR, COEF_ONE, SEL_AI, COEF_ZERO);
    t[1] = mk_term(SEL_AI, COEF_ONE, SEL_AR, COEF_ZERO);
    t[2] = mk_term(SEL_BR, COEF_ONE, SEL_BI, COEF_ZERO);
    t[3] = mk_term(SEL_BI, COEF_ONE, SEL_BR, COEF_ZERO);
    return t;
  endfunction

endpackage

FILE: rtl/svge_ram.sv
// Generic RAM with one write port and two registered read ports.
module svge_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

FILE: rtl/svge_front.sv
// Front end: accepts items, checks qubit indexes, builds gate coefficients, queues commands.
module svge_front
  import svge_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [3:0]                  active_qubits,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [3:0]                  gate_kind,
  input  logic [MAX_QUBITS-1:0]       amp_index,
  input  logic signed [AMP_WIDTH-1:0] write_re,
  input  logic signed [AMP_WIDTH-1:0] write_im,
  input  logic [3:0]                  target_qubit,
  input  logic [3:0]                  control_qubit,
  input  logic signed [17:0]          cos_half,
  input  logic signed [17:0]          sin_half,
  output logic                        q_valid,
  input  logic                        q_pop,
  output ctrl_t                       q_ctrl,
  output terms_t                      q_terms,
  output logic [MAX_QUBITS-1:0]       q_idx,
  output logic signed [AMP_WIDTH-1:0] q_wre,
  output logic signed [AMP_WIDTH-1:0] q_wim
);

  localparam int EntW = $bits(ctrl_t) + $bits(terms_t) + MAX_QUBITS + 2 * AMP_WIDTH;

  ctrl_t ctrl;
  terms_t terms;
  logic [4:0] nq;
  logic bad;
  coef_t c, s, ns;

  logic [EntW-1:0] fifo [2];
  logic wptr, rptr;
  logic [1:0] count;
  logic push;

  always_comb begin
    if (active_qubits == 4'd0) begin
      nq = 5'd1;
    end else if ({1'b0, active_qubits} > 5'(MAX_QUBITS)) begin
      nq = 5'(MAX_QUBITS);
    end else begin
      nq = {1'b0, active_qubits};
    end
    bad = ({1'b0, target_qubit} >= nq) ||
          ((gate_kind == GK_CNOT) &&
           (({1'b0, control_qubit} >= nq) || (control_qubit == target_qubit)));

    ctrl.tgt = target_qubit;
    ctrl.ctl = control_qubit;
    ctrl.cnot = (gate_kind == GK_CNOT);
    ctrl.nq = nq;
    unique case (operation)
      OP_WRITE: ctrl.cmd = CMD_WRITE;
      OP_READ:  ctrl.cmd = CMD_READ;
      OP_GATE: begin
        if (gate_kind > GK_RZ) begin
          ctrl.cmd = CMD_NONE;
        end else if (bad) begin
          ctrl.cmd = CMD_FAIL;
        end else begin
          ctrl.cmd = CMD_GATE;
        end
      end
      default:  ctrl.cmd = CMD_NONE;
    endcase
  end

  always_comb begin
    c = coef_t'(cos_half);
    s = coef_t'(sin_half);
    ns = -s;
    terms = ident_terms();
    unique case (gate_kind)
      GK_X, GK_CNOT: begin
        terms[0] = mk_term(SEL_BR, COEF_ONE, SEL_BI, COEF_ZERO);
        terms[1] = mk_term(SEL_BI, COEF_ONE, SEL_BR, COEF_ZERO);
        terms[2] = mk_term(SEL_AR, COEF_ONE, SEL_AI, COEF_ZERO);
        terms[3] = mk_term(SEL_AI, COEF_ONE, SEL_AR, COEF_ZERO);
      end
      GK_Y: begin
        terms[0] = mk_term(SEL_BI, COEF_ONE, SEL_BR, COEF_ZERO);
        terms[1] = mk_term(SEL_BR, COEF_MONE, SEL_BI, COEF_ZERO);
        terms[2] = mk_term(SEL_AI, COEF_MONE, SEL_AR, COEF_ZERO);
        terms[3] = mk_term(SEL_AR, COEF_ONE, SEL_AI, COEF_ZERO);
      end
      GK_Z: begin
        terms[2] = mk_term(SEL_BR, COEF_MONE, SEL_BI, COEF_ZERO);
        terms[3] = mk_term(SEL_BI, COEF_MONE, SEL_BR, COEF_ZERO);
      end
      GK_H: begin
        terms[0] = mk_term(SEL_AR, COEF_K, SEL_BR, COEF_K);
        terms[1] = mk_term(SEL_AI, COEF_K, SEL_BI, COEF_K);
        terms[2] = mk_term(SEL_AR, COEF_K, SEL_BR, COEF_MK);
        terms[3] = mk_term(SEL_AI, COEF_K, SEL_BI, COEF_MK);
      end
      GK_S: begin
        terms[2] = mk_term(SEL_BI, COEF_MONE, SEL_BR, COEF_ZERO);
        terms[3] = mk_term(SEL_BR, COEF_ONE, SEL_BI, COEF_ZERO);
      end
      GK_SDG: begin
        terms[2] = mk_term(SEL_BI, COEF_ONE, SEL_BR, COEF_ZERO);
        terms[3] = mk_term(SEL_BR, COEF_MONE, SEL_BI, COEF_ZERO);
      end
      GK_T: begin
        terms[2] = mk_term(SEL_BR, COEF_K, SEL_BI, COEF_MK);
        terms[3] = mk_term(SEL_BR, COEF_K, SEL_BI, COEF_K);
      end
      GK_TDG: begin
        terms[2] = mk_term(SEL_BR, COEF_K, SEL_BI, COEF_K);
        terms[3] = mk_term(SEL_BR, COEF_MK, SEL_BI, COEF_K);
      end
      GK_RX: begin
        terms[0] = mk_term(SEL_AR, c, SEL_BI, s);
        terms[1] = mk_term(SEL_AI, c, SEL_BR, ns);
        terms[2] = mk_term(SEL_AI, s, SEL_BR, c);
        terms[3] = mk_term(SEL_BI, c, SEL_AR, ns);
      end
      GK_RY: begin
        terms[0] = mk_term(SEL_AR, c, SEL_BR, ns);
        terms[1] = mk_term(SEL_AI, c, SEL_BI, ns);
        terms[2] = mk_term(SEL_AR, s, SEL_BR, c);
        terms[3] = mk_term(SEL_AI, s, SEL_BI, c);
      end
      GK_RZ: begin
        terms[0] = mk_term(SEL_AR, c, SEL_AI, s);
        terms[1] = mk_term(SEL_AI, c, SEL_AR, ns);
        terms[2] = mk_term(SEL_BR, c, SEL_BI, ns);
        terms[3] = mk_term(SEL_BI, c, SEL_BR, s);
      end
      default: terms = ident_terms();
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (count != 2'd0);
  assign {q_ctrl, q_terms, q_idx, q_wre, q_wim} = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= {ctrl, terms, amp_index, write_re, write_im};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (q_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/svge_back.sv
// Back end: runs queued commands against the amplitude memory and registers each result.
module svge_back
  import svge_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH = 18
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_pop,
  input  ctrl_t                       q_ctrl,
  input  terms_t                      q_terms,
  input  logic [MAX_QUBITS-1:0]       q_idx,
  input  logic signed [AMP_WIDTH-1:0] q_wre,
  input  logic signed [AMP_WIDTH-1:0] q_wim,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic signed [AMP_WIDTH-1:0] res_re,
  output logic signed [AMP_WIDTH-1:0] res_im,
  output logic                        res_status
);

  localparam int AW = MAX_QUBITS;
  localparam int CW = AW - 1;
  localparam int DW = 2 * AMP_WIDTH;
  localparam int PW = CoefW + AMP_WIDTH;
  localparam int SW = PW + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WR    = 9'b000000010,
    S_RADDR = 9'b000000100,
    S_RDATA = 9'b000001000,
    S_PRD   = 9'b000010000,
    S_PMUL  = 9'b000100000,
    S_PSUM  = 9'b001000000,
    S_PWA   = 9'b010000000,
    S_PWB   = 9'b100000000
  } state_t;

  state_t state, state_next;
  ctrl_t cur;
  terms_t cur_terms;
  logic [AW-1:0] cur_idx;
  logic signed [AMP_WIDTH-1:0] cur_wre, cur_wim;
  logic [CW-1:0] cnt, last_cnt;
  logic [AW-1:0] cntx, tmask, ia, ib, ia_sh;

  logic we;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [DW-1:0] wdata, rdata0, rdata1;

  logic signed [AMP_WIDTH-1:0] xs [4];
  terms_t use_terms;
  logic signed [PW-1:0] p1 [4];
  logic signed [PW-1:0] p2 [4];
  logic signed [AMP_WIDTH-1:0] r [4];

  logic pend;
  logic pend_status;
  logic signed [AMP_WIDTH-1:0] pend_re, pend_im;
  logic done;

  function automatic logic signed [AMP_WIDTH-1:0] round_sat(logic signed [PW-1:0] a,
                                                            logic signed [PW-1:0] b);
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] sh;
    logic signed [SW-1:0] maxv;
    logic signed [SW-1:0] minv;
    sum = SW'(a) + SW'(b) + SW'(1 << (CoefShift - 1));
    sh = sum >>> CoefShift;
    maxv = SW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
    minv = -maxv - SW'(1);
    if (sh > maxv) begin
      return AMP_WIDTH'(maxv);
    end else if (sh < minv) begin
      return AMP_WIDTH'(minv);
    end
    return AMP_WIDTH'(sh);
  endfunction

  svge_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // Pair addresses: the counter with a zero bit inserted at the target position.
  always_comb begin
    cntx = AW'(cnt);
    tmask = ~({AW{1'b1}} << cur.tgt);
    ia = (cntx & tmask) | ((cntx & ~tmask) << 1);
    ib = ia | (AW'(1) << cur.tgt);
    ia_sh = ia >> cur.ctl;
    last_cnt = ~({CW{1'b1}} << (cur.nq - 5'd1));
  end

  always_comb begin
    xs[0] = rdata0[AMP_WIDTH-1:0];
    xs[1] = rdata0[DW-1:AMP_WIDTH];
    xs[2] = rdata1[AMP_WIDTH-1:0];
    xs[3] = rdata1[DW-1:AMP_WIDTH];
    // A CNOT leaves the pair alone when the control bit of a is clear.
    use_terms = (cur.cnot && !ia_sh[0]) ? ident_terms() : cur_terms;
  end

  always_ff @(posedge clk) begin
    if (state == S_PMUL) begin
      for (int j = 0; j < 4; j++) begin
        p1[j] <= use_terms[j].coef1 * xs[use_terms[j].sel1];
        p2[j] <= use_terms[j].coef2 * xs[use_terms[j].sel2];
      end
    end
    if (state == S_PSUM) begin
      for (int j = 0; j < 4; j++) begin
        r[j] <= round_sat(p1[j], p2[j]);
      end
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = ia;
    wdata = {r[1], r[0]};
    raddr0 = ia;
    raddr1 = ib;
    unique case (state)
      S_WR: begin
        we = 1'b1;
        waddr = cur_idx;
        wdata = {cur_wim, cur_wre};
      end
      S_RADDR: raddr0 = cur_idx;
      S_PWA:   we = 1'b1;
      S_PWB: begin
        we = 1'b1;
        waddr = ib;
        wdata = {r[3], r[2]};
      end
      default: ;
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid && !pend;
  assign done = pend && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_pop) begin
          unique case (q_ctrl.cmd)
            CMD_WRITE: state_next = S_WR;
            CMD_READ:  state_next = S_RADDR;
            CMD_GATE:  state_next = S_PRD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_WR:    state_next = S_IDLE;
      S_RADDR: state_next = S_RDATA;
      S_RDATA: state_next = S_IDLE;
      S_PRD:   state_next = S_PMUL;
      S_PMUL:  state_next = S_PSUM;
      S_PSUM:  state_next = S_PWA;
      S_PWA:   state_next = S_PWB;
      S_PWB:   state_next = (cnt == last_cnt) ? S_IDLE : S_PRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_ctrl;
      cur_terms <= q_terms;
      cur_idx <= q_idx;
      cur_wre <= q_wre;
      cur_wim <= q_wim;
    end
    if (q_pop) begin
      pend_re <= '0;
      pend_im <= '0;
      pend_status <= (q_ctrl.cmd == CMD_FAIL);
    end else if (state == S_RDATA) begin
      pend_re <= rdata0[AMP_WIDTH-1:0];
      pend_im <= rdata0[DW-1:AMP_WIDTH];
    end
    if (done) begin
      res_re <= pend_re;
      res_im <= pend_im;
      res_status <= pend_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_PWB) begin
        cnt <= (cnt == last_cnt) ? '0 : cnt + CW'(1);
      end
      // The result is pending once the command's work is finished.
      if (done) begin
        pend <= 1'b0;
      end else if ((q_pop && (q_ctrl.cmd == CMD_NONE || q_ctrl.cmd == CMD_FAIL)) ||
                   (state == S_WR) || (state == S_RDATA) ||
                   (state == S_PWB && cnt == last_cnt)) begin
        pend <= 1'b1;
      end
      if (done) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/statevector_gate_engine.sv
// Top level of the state-vector gate engine: stream ports, config register, front and back.
//
// Usage:
// The input stream carries one item per handshake: a write or read of one amplitude,
// or one gate over the whole active vector. Every item gives exactly one output item
// (read data for a read, zeros otherwise, plus a status bit set for a bad qubit index).
// A front end checks and decodes items into a two-entry command queue; a back end
// drains the queue against a single amplitude memory with two read ports and one
// write port. A gate walks the 2^(n-1) pairs of n active qubits one at a time, each
// pair in turn read, multiplied, rounded and written back as a and then as b.
// Rejected or unknown gates give their result without touching the memory.
// The active_qubits register (address 0) is written through the APB port; the user
// must write it only while idle, and the block itself does not enforce this.
// Reset empties the queue and the output register and sets active_qubits to 10;
// amplitudes are undefined until written. If the receiver stalls, the finished result
// holds in the output register, the back end waits, and the queue takes items until full.
module statevector_gate_engine
  import svge_pkg::*;
#(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // amp_index, write_re, write_im, target_qubit, control_qubit, cos_half, sin_half
  input  logic [((MAX_QUBITS + 2 * AMP_WIDTH + 44 + 7) / 8) * 8 - 1:0] s_tdata,
  // operation, gate_kind
  input  logic [5:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_re, read_im, status
  output logic [((2 * AMP_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int InW = ((MAX_QUBITS + 2 * AMP_WIDTH + 44 + 7) / 8) * 8;
  localparam int OutW = ((2 * AMP_WIDTH + 1 + 7) / 8) * 8;
  localparam int PosRe = MAX_QUBITS;
  localparam int PosIm = PosRe + AMP_WIDTH;
  localparam int PosTgt = PosIm + AMP_WIDTH;
  localparam int PosCtl = PosTgt + 4;
  localparam int PosCos = PosCtl + 4;
  localparam int PosSin = PosCos + 18;

  logic [3:0] active_qubits;

  logic q_valid, q_pop;
  ctrl_t q_ctrl;
  terms_t q_terms;
  logic [MAX_QUBITS-1:0] q_idx;
  logic signed [AMP_WIDTH-1:0] q_wre, q_wim;
  logic signed [AMP_WIDTH-1:0] res_re, res_im;
  logic res_status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, active_qubits} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_qubits <= 4'd10;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      active_qubits <= pwdata[3:0];
    end
  end

  svge_front #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_front (
    .clk           (clk),
    .rst           (rst),
    .active_qubits (active_qubits),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .operation     (s_tuser[1:0]),
    .gate_kind     (s_tuser[5:2]),
    .amp_index     (s_tdata[MAX_QUBITS-1:0]),
    .write_re      (s_tdata[PosRe +: AMP_WIDTH]),
    .write_im      (s_tdata[PosIm +: AMP_WIDTH]),
    .target_qubit  (s_tdata[PosTgt +: 4]),
    .control_qubit (s_tdata[PosCtl +: 4]),
    .cos_half      (s_tdata[PosCos +: 18]),
    .sin_half      (s_tdata[PosSin +: 18]),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_ctrl        (q_ctrl),
    .q_terms       (q_terms),
    .q_idx         (q_idx),
    .q_wre         (q_wre),
    .q_wim         (q_wim)
  );

  svge_back #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_ctrl     (q_ctrl),
    .q_terms    (q_terms),
    .q_idx      (q_idx),
    .q_wre      (q_wre),
    .q_wim      (q_wim),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_re     (res_re),
    .res_im     (res_im),
    .res_status (res_status)
  );

  assign m_tdata = OutW'({res_status, res_im, res_re});

  // The top bits of s_tdata are padding and carry nothing.
  logic unused_pad;
  assign unused_pad = ^s_tdata[InW-1:PosSin+18];

endmodule
